// ===== src/cidnm_pkg.sv =====
// Shared types and constants for the color identifier nearest-match block.
`default_nettype none
package cidnm_pkg;

  localparam int CHANNEL_BITS        = 8;
  localparam int MAX_ENTRIES_DEFAULT = 256;
  localparam int IDX_PORT_W          = 8;
  localparam int ENTRIES_W           = 9;
  localparam int DIST_W              = 2 * CHANNEL_BITS + 2;
  localparam int CFG_DATA_W          = 18;
  localparam int CFG_IDX_W           = 2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_PICK  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRIES_IN_USE = 2'd0,
    REG_BLACK_LIMIT    = 2'd1,
    REG_MATCH_LIMIT    = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BLACK,
    ST_BLACK_WAIT,
    ST_WALK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic usable;
    rgb_t colour;
  } entry_t;

  typedef struct packed {
    logic [ENTRIES_W-1:0] entries_in_use;
    logic [DIST_W-1:0]    black_limit_sq;
    logic [DIST_W-1:0]    match_limit_sq;
  } cfg_t;

  typedef struct packed {
    logic                  op;
    logic [IDX_PORT_W-1:0] entry_index;
    rgb_t                  colour;
    logic                  entry_usable;
  } in_req_t;

  typedef struct packed {
    logic                  found;
    logic                  rejected_black;
    logic [IDX_PORT_W-1:0] match_index;
    logic [DIST_W-1:0]     match_distance_sq;
  } out_res_t;

  typedef struct packed {
    logic   valid;
    logic   usable;
    rgb_t   colour;
  } dist_req_t;

  typedef struct packed {
    logic              valid;
    logic              usable;
    logic [DIST_W-1:0] sq_dist;
  } dist_res_t;

endpackage
`default_nettype wire

// ===== src/cidnm_table.sv =====
// Entry table memory: one write port, one read port with registered data.
`default_nettype none
module cidnm_table #(
  parameter int Depth = cidnm_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  cidnm_pkg::entry_t        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output cidnm_pkg::entry_t        rdata_o
);
  import cidnm_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/cidnm_dist.sv =====
// Two-stage squared Euclidean distance unit between a pixel and a colour.
`default_nettype none
module cidnm_dist #(
  parameter int IdxW = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cidnm_pkg::dist_req_t req_i,
  input  logic [IdxW-1:0]      idx_i,
  input  cidnm_pkg::rgb_t      px_i,
  output cidnm_pkg::dist_res_t res_o,
  output logic [IdxW-1:0]      idx_o,
  output logic                 busy_o
);
  import cidnm_pkg::*;

  localparam int SqW = 2 * CHANNEL_BITS;

  function automatic logic [CHANNEL_BITS-1:0] abs_diff(
    input logic [CHANNEL_BITS-1:0] a,
    input logic [CHANNEL_BITS-1:0] b
  );
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [CHANNEL_BITS-1:0] dr, dg, db;
  logic [SqW-1:0]          sq_r_q, sq_g_q, sq_b_q;
  logic                    a_vld_q, a_usable_q;
  logic [IdxW-1:0]         a_idx_q;
  logic                    b_vld_q, b_usable_q;
  logic [IdxW-1:0]         b_idx_q;
  logic [DIST_W-1:0]       b_dist_q;

  assign dr = abs_diff(px_i.red,   req_i.colour.red);
  assign dg = abs_diff(px_i.green, req_i.colour.green);
  assign db = abs_diff(px_i.blue,  req_i.colour.blue);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else begin
      a_vld_q <= req_i.valid;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_r_q     <= SqW'(dr) * SqW'(dr);
    sq_g_q     <= SqW'(dg) * SqW'(dg);
    sq_b_q     <= SqW'(db) * SqW'(db);
    a_usable_q <= req_i.usable;
    a_idx_q    <= idx_i;
    b_dist_q   <= DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);
    b_usable_q <= a_usable_q;
    b_idx_q    <= a_idx_q;
  end

  assign res_o.valid   = b_vld_q;
  assign res_o.usable  = b_usable_q;
  assign res_o.sq_dist = b_dist_q;
  assign idx_o         = b_idx_q;
  assign busy_o        = a_vld_q | b_vld_q;

endmodule
`default_nettype wire

// ===== src/cidnm_ctrl.sv =====
// Sequencer: table clear, entry writes, black check, table walk and result register.
`default_nettype none
module cidnm_ctrl #(
  parameter int MaxEntries = cidnm_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cidnm_pkg::cfg_t               cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cidnm_pkg::in_req_t            in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cidnm_pkg::out_res_t           out_res_o,
  output logic                          mem_we_o,
  output logic [$clog2(MaxEntries)-1:0] mem_waddr_o,
  output cidnm_pkg::entry_t             mem_wdata_o,
  output logic                          mem_re_o,
  output logic [$clog2(MaxEntries)-1:0] mem_raddr_o,
  input  cidnm_pkg::entry_t             mem_rdata_i,
  output cidnm_pkg::dist_req_t          dist_req_o,
  output logic [$clog2(MaxEntries)-1:0] dist_idx_o,
  output cidnm_pkg::rgb_t               dist_px_o,
  input  cidnm_pkg::dist_res_t          dist_res_i,
  input  logic [$clog2(MaxEntries)-1:0] dist_idx_i,
  input  logic                          dist_busy_i
);
  import cidnm_pkg::*;

  localparam int IdxW = $clog2(MaxEntries);
  localparam int CntW = ($clog2(MaxEntries + 1) > ENTRIES_W) ? $clog2(MaxEntries + 1)
                                                            : ENTRIES_W;
  localparam int ExtW = (IdxW > IDX_PORT_W) ? IdxW : IDX_PORT_W;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, n_q, n_d, eu_ext;
  rgb_t              px_q;
  logic [DIST_W-1:0] best_q;
  logic [IdxW-1:0]   best_idx_q, rd_idx_q;
  logic              found_q, reject_q, rd_vld_q;
  logic              out_valid_q;
  out_res_t          out_res_q;
  logic [ExtW-1:0]   wr_idx_ext, best_idx_ext;
  logic              wr_in_range, pick_start, black_issue, load_out, reject_hit, best_hit;

  assign eu_ext       = CntW'(cfg_i.entries_in_use);
  assign n_d          = (eu_ext > CntW'(MaxEntries)) ? CntW'(MaxEntries) : eu_ext;
  assign wr_idx_ext   = ExtW'(in_req_i.entry_index);
  assign wr_in_range  = ({1'b0, wr_idx_ext} < (ExtW + 1)'(MaxEntries));
  assign best_idx_ext = ExtW'(best_idx_q);
  assign reject_hit   = dist_res_i.sq_dist < cfg_i.black_limit_sq;
  assign best_hit     = (state_q == ST_WALK) && dist_res_i.valid && dist_res_i.usable
                        && (dist_res_i.sq_dist < best_q);

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q[IdxW-1:0];
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    pick_start  = 1'b0;
    black_issue = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we_o = 1'b1;
        if (cnt_q == CntW'(MaxEntries - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_req_i.op == OP_WRITE) begin
            mem_we_o           = wr_in_range;
            mem_waddr_o        = wr_idx_ext[IdxW-1:0];
            mem_wdata_o.usable = in_req_i.entry_usable;
            mem_wdata_o.colour = in_req_i.colour;
          end else begin
            pick_start = 1'b1;
            state_d    = ST_BLACK;
          end
        end
      end
      ST_BLACK: begin
        black_issue = 1'b1;
        state_d     = ST_BLACK_WAIT;
      end
      ST_BLACK_WAIT: begin
        if (dist_res_i.valid) begin
          state_d = reject_hit ? ST_FINISH : ST_WALK;
        end
      end
      ST_WALK: begin
        if (cnt_q < n_q) begin
          mem_re_o = 1'b1;
        end else if (!rd_vld_q && !dist_busy_i) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign mem_raddr_o = cnt_q[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= mem_re_o;
      if (pick_start) begin
        cnt_q <= '0;
      end else if (state_q == ST_CLEAR || mem_re_o) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= mem_raddr_o;
    if (pick_start) begin
      px_q       <= in_req_i.colour;
      n_q        <= n_d;
      best_q     <= cfg_i.match_limit_sq;
      best_idx_q <= '0;
      found_q    <= 1'b0;
      reject_q   <= 1'b0;
    end else begin
      if (state_q == ST_BLACK_WAIT && dist_res_i.valid && reject_hit) begin
        reject_q <= 1'b1;
      end
      if (best_hit) begin
        best_q     <= dist_res_i.sq_dist;
        best_idx_q <= dist_idx_i;
        found_q    <= 1'b1;
      end
    end
    if (load_out) begin
      out_res_q.found             <= found_q;
      out_res_q.rejected_black    <= reject_q;
      out_res_q.match_index       <= best_idx_ext[IDX_PORT_W-1:0];
      out_res_q.match_distance_sq <= found_q ? best_q : '0;
    end
  end

  assign dist_req_o.valid  = rd_vld_q | black_issue;
  assign dist_req_o.usable = black_issue | mem_rdata_i.usable;
  assign dist_req_o.colour = black_issue ? '0 : mem_rdata_i.colour;
  assign dist_idx_o        = rd_idx_q;
  assign dist_px_o         = px_q;
  assign out_valid_o       = out_valid_q;
  assign out_res_o         = out_res_q;

  a_best_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (best_q <= cfg_i.match_limit_sq))
    else $error("best distance above match limit");

  a_walk_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (cnt_q <= n_q))
    else $error("walk counter past search length");

  a_write_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == ST_CLEAR || state_q == ST_IDLE))
    else $error("table write during a search");

  a_dist_when_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_res_i.valid |-> (state_q == ST_BLACK_WAIT || state_q == ST_WALK))
    else $error("distance result with no consumer");

  a_found_xor_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_res_q.found && out_res_q.rejected_black))
    else $error("result both found and rejected");

endmodule
`default_nettype wire

// ===== src/color_id_nearest_match.sv =====
// Top level of the color identifier nearest-match block.
//
// Input channel (in_valid_i/in_ready_o): op_i = 0 stores red/green/blue and the usable flag
// at entry_index_i (indexes at or above MAX_ENTRIES are dropped) and produces no result.
// op_i = 1 is a pick: the pixel is first checked against black_limit_sq, then the first
// min(entries_in_use, MAX_ENTRIES) table entries are walked for the nearest usable one with a
// squared distance strictly below match_limit_sq, lowest index winning ties.
// Output channel (out_valid_o/out_ready_i): one result per pick, held in an output register.
// Timing: a write request is stored on the edge that accepts it. A rejected pick goes from
// its black check straight to the result register; a full pick first walks the table entries,
// read by the single table read port (one entry per cycle) into the two-stage distance unit.
// One request is in work at a time: a new one is taken only once the last pick has loaded its
// result. Writes are still taken while a result waits, and a finished pick holds until the
// output register is free.
// Reset: a clearing pass writes every table entry to not usable, with in_ready_o low.
// entries_in_use and match_limit_sq are sampled when a pick is accepted and black_limit_sq
// during its black check, so the user must write configuration between picks (not enforced).
`default_nettype none
module color_id_nearest_match #(
  parameter int MAX_ENTRIES = cidnm_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cidnm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [cidnm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                op_i,
  input  logic [cidnm_pkg::IDX_PORT_W-1:0]    entry_index_i,
  input  logic [cidnm_pkg::CHANNEL_BITS-1:0]  red_i,
  input  logic [cidnm_pkg::CHANNEL_BITS-1:0]  green_i,
  input  logic [cidnm_pkg::CHANNEL_BITS-1:0]  blue_i,
  input  logic                                entry_usable_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                found_o,
  output logic                                rejected_black_o,
  output logic [cidnm_pkg::IDX_PORT_W-1:0]    match_index_o,
  output logic [cidnm_pkg::DIST_W-1:0]        match_distance_sq_o
);
  import cidnm_pkg::*;

  localparam int IdxW = $clog2(MAX_ENTRIES);

  cfg_t            cfg_q;
  in_req_t         in_req;
  out_res_t        out_res;
  logic            mem_we, mem_re, dist_busy;
  logic [IdxW-1:0] mem_waddr, mem_raddr, dist_idx_in, dist_idx_out;
  entry_t          mem_wdata, mem_rdata;
  dist_req_t       dist_req;
  dist_res_t       dist_res;
  rgb_t            dist_px;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.entries_in_use <= '0;
      cfg_q.black_limit_sq <= DIST_W'(1);
      cfg_q.match_limit_sq <= DIST_W'(65025);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ENTRIES_IN_USE: cfg_q.entries_in_use <= cfg_wdata_i[ENTRIES_W-1:0];
        REG_BLACK_LIMIT:    cfg_q.black_limit_sq <= cfg_wdata_i[DIST_W-1:0];
        REG_MATCH_LIMIT:    cfg_q.match_limit_sq <= cfg_wdata_i[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_req.op           = op_i;
  assign in_req.entry_index  = entry_index_i;
  assign in_req.colour.red   = red_i;
  assign in_req.colour.green = green_i;
  assign in_req.colour.blue  = blue_i;
  assign in_req.entry_usable = entry_usable_i;

  cidnm_table #(
    .Depth (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cidnm_dist #(
    .IdxW (IdxW)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dist_req),
    .idx_i  (dist_idx_in),
    .px_i   (dist_px),
    .res_o  (dist_res),
    .idx_o  (dist_idx_out),
    .busy_o (dist_busy)
  );

  cidnm_ctrl #(
    .MaxEntries (MAX_ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .dist_req_o  (dist_req),
    .dist_idx_o  (dist_idx_in),
    .dist_px_o   (dist_px),
    .dist_res_i  (dist_res),
    .dist_idx_i  (dist_idx_out),
    .dist_busy_i (dist_busy)
  );

  assign found_o             = out_res.found;
  assign rejected_black_o    = out_res.rejected_black;
  assign match_index_o       = out_res.match_index;
  assign match_distance_sq_o = out_res.match_distance_sq;

endmodule
`default_nettype wire
